[hw/rtl/aiv_pkg.sv]
// Shared types and constants for the arcade I/O port and banked video RAM unit.
// Used by every module in hw/rtl; depends on nothing else.
package aiv_pkg;

    // Default geometry of the banked video RAM.
    localparam int BANK_BYTES = 4096;
    localparam int BANK_COUNT = 4;

    // Item opcodes.
    localparam logic [2:0] OP_PORT_WR = 3'd0;
    localparam logic [2:0] OP_PORT_RD = 3'd1;
    localparam logic [2:0] OP_VRAM_WR = 3'd2;
    localparam logic [2:0] OP_VRAM_RD = 3'd3;
    localparam logic [2:0] OP_KEY_DN  = 3'd4;
    localparam logic [2:0] OP_KEY_UP  = 3'd5;

    // Port numbers with a meaning of their own.
    localparam logic [11:0] PORT_SOUND   = 12'd0;
    localparam logic [11:0] PORT_IN0     = 12'd0;
    localparam logic [11:0] PORT_ROMBANK = 12'd1;
    localparam logic [11:0] PORT_IN1     = 12'd1;
    localparam logic [11:0] PORT_IN2     = 12'd2;
    localparam logic [11:0] PORT_DIP_A   = 12'd3;
    localparam logic [11:0] PORT_DIP_B   = 12'd4;
    localparam logic [11:0] PORT_CTRL    = 12'd4;
    localparam logic [11:0] PORT_IN5     = 12'd5;
    localparam logic [11:0] PORT_SCX_LO  = 12'd8;
    localparam logic [11:0] PORT_SCX_HI  = 12'd9;
    localparam logic [11:0] PORT_SCY_LO  = 12'd10;
    localparam logic [11:0] PORT_SCY_HI  = 12'd11;
    localparam logic [11:0] PORT_LAYERS  = 12'd12;
    localparam logic [11:0] PORT_VBANK   = 12'd13;
    localparam logic [11:0] PORT_LAYOUT  = 12'd14;
    localparam logic [11:0] PORT_LAST    = 12'd15;

    // Configuration register indexes.
    localparam logic CFG_DIP_A = 1'b0;
    localparam logic CFG_DIP_B = 1'b1;

    // Reset values.
    localparam logic [7:0] DIP_A_RESET = 8'h8f;
    localparam logic [7:0] DIP_B_RESET = 8'hff;
    localparam logic [7:0] PORT_IN_RESET = 8'hff;
    localparam logic [7:0] PORT_IN5_VALUE = 8'h01;

    // One input item.
    typedef struct packed {
        logic [2:0]  opcode;
        logic [11:0] address;
        logic [7:0]  write_data;
        logic [3:0]  key_index;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [7:0]         read_data;
        logic [3:0]         rom_bank;
        logic signed [15:0] scroll_x;
        logic signed [15:0] scroll_y;
        logic               background_on;
        logic               sprites_on;
        logic               text_on;
        logic               wide_layout;
        logic [1:0]         vram_bank;
        logic               audio_stop;
        logic               sound_write;
        logic [7:0]         sound_data;
    } t_result;

    // Video control state held by the port block.
    typedef struct packed {
        logic [3:0]         rom_bank;
        logic signed [15:0] scroll_x;
        logic signed [15:0] scroll_y;
        logic               background_on;
        logic               sprites_on;
        logic               text_on;
        logic               wide_layout;
        logic [1:0]         vram_bank;
    } t_video_state;

    // Per-item side results of the port block.
    typedef struct packed {
        logic [7:0] port_data;
        logic       audio_stop;
        logic       sound_write;
        logic [7:0] sound_data;
    } t_port_resp;

endpackage

[hw/rtl/aiv_vram.sv]
// Banked video RAM: single-port synchronous memory with registered read data.
// Depends on aiv_pkg for the default geometry.
module aiv_vram #(
    parameter int BANK_BYTES = aiv_pkg::BANK_BYTES,
    parameter int BANK_COUNT = aiv_pkg::BANK_COUNT
) (
    input  logic        i_clk,
    input  logic        i_wr_en,
    input  logic        i_rd_en,
    input  logic [1:0]  i_bank,
    input  logic [11:0] i_offset,
    input  logic [7:0]  i_wr_data,
    output logic [7:0]  o_rd_data
);
    localparam int DEPTH  = BANK_BYTES * BANK_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int OFF_W  = $clog2(BANK_BYTES);

    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_rd_data;
    logic [1:0]        bank_mod;
    logic [ADDR_W-1:0] mem_addr;

    // Fold the bank number into the banks that exist, then place the offset.
    always_comb begin
        bank_mod = i_bank;
        for (int k = 0; k < 3; k++) begin
            if ({1'b0, bank_mod} >= 3'(BANK_COUNT)) begin
                bank_mod = bank_mod - 2'(BANK_COUNT);
            end
        end
        mem_addr = (ADDR_W'(bank_mod) << OFF_W) | ADDR_W'(i_offset);
    end

    // Memory array with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[mem_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/aiv_ports.sv]
// I/O port registers: sound command, ROM bank, layer flags, scroll, bank select,
// input ports and DIP switches. Depends on aiv_pkg.
module aiv_ports (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  aiv_pkg::t_item        i_item,
    input  logic                  i_cfg_wr,
    input  logic                  i_cfg_index,
    input  logic [7:0]            i_cfg_data,
    output aiv_pkg::t_video_state o_state,
    output aiv_pkg::t_port_resp   o_resp
);
    logic [7:0]  r_dip_a, n_dip_a;
    logic [7:0]  r_dip_b, n_dip_b;
    logic [7:0]  r_in0, n_in0;
    logic [7:0]  r_in1, n_in1;
    logic [15:0] r_scx, n_scx;
    logic [15:0] r_scy, n_scy;
    logic [3:0]  r_rom, n_rom;
    logic [7:0]  r_bank, n_bank;
    logic        r_bg, n_bg;
    logic        r_spr, n_spr;
    logic        r_txt, n_txt;
    logic        r_wide, n_wide;
    logic [7:0]  key_mask;
    logic        port_ok;

    assign port_ok  = (i_item.address <= aiv_pkg::PORT_LAST);
    assign key_mask = 8'(1) << i_item.key_index[2:0];

    // Next state of every port register for the item in hand.
    always_comb begin
        n_dip_a = r_dip_a;
        n_dip_b = r_dip_b;
        n_in0   = r_in0;
        n_in1   = r_in1;
        n_scx   = r_scx;
        n_scy   = r_scy;
        n_rom   = r_rom;
        n_bank  = r_bank;
        n_bg    = r_bg;
        n_spr   = r_spr;
        n_txt   = r_txt;
        n_wide  = r_wide;
        o_resp  = '0;

        if (i_cfg_wr) begin
            unique case (i_cfg_index)
                aiv_pkg::CFG_DIP_A: n_dip_a = i_cfg_data;
                aiv_pkg::CFG_DIP_B: n_dip_b = i_cfg_data;
                default: ;
            endcase
        end

        // Port read data, taken from the state before this item.
        if (port_ok) begin
            case (i_item.address)
                aiv_pkg::PORT_IN0:    o_resp.port_data = r_in0;
                aiv_pkg::PORT_IN1:    o_resp.port_data = r_in1;
                aiv_pkg::PORT_IN2:    o_resp.port_data = aiv_pkg::PORT_IN_RESET;
                aiv_pkg::PORT_DIP_A:  o_resp.port_data = r_dip_a;
                aiv_pkg::PORT_DIP_B:  o_resp.port_data = r_dip_b;
                aiv_pkg::PORT_IN5:    o_resp.port_data = aiv_pkg::PORT_IN5_VALUE;
                aiv_pkg::PORT_SCX_LO: o_resp.port_data = r_scx[7:0];
                aiv_pkg::PORT_SCX_HI: o_resp.port_data = r_scx[15:8];
                aiv_pkg::PORT_SCY_LO: o_resp.port_data = r_scy[7:0];
                aiv_pkg::PORT_SCY_HI: o_resp.port_data = r_scy[15:8];
                default:              o_resp.port_data = 8'h00;
            endcase
        end
        if (i_item.opcode != aiv_pkg::OP_PORT_RD) begin
            o_resp.port_data = 8'h00;
        end

        if (i_accept) begin
            unique case (i_item.opcode)
                aiv_pkg::OP_PORT_WR: begin
                    if (port_ok) begin
                        case (i_item.address)
                            aiv_pkg::PORT_SOUND: begin
                                o_resp.sound_write = 1'b1;
                                o_resp.sound_data  = i_item.write_data;
                            end
                            aiv_pkg::PORT_ROMBANK: n_rom = i_item.write_data[3:0];
                            aiv_pkg::PORT_CTRL: begin
                                o_resp.audio_stop = i_item.write_data[5];
                                n_txt             = ~i_item.write_data[7];
                            end
                            aiv_pkg::PORT_SCX_LO: n_scx[7:0]  = i_item.write_data;
                            aiv_pkg::PORT_SCX_HI: n_scx[15:8] = i_item.write_data;
                            aiv_pkg::PORT_SCY_LO: n_scy[7:0]  = i_item.write_data;
                            aiv_pkg::PORT_SCY_HI: n_scy[15:8] = i_item.write_data;
                            aiv_pkg::PORT_LAYERS: begin
                                n_bg  = ~i_item.write_data[1];
                                n_spr = ~i_item.write_data[2];
                            end
                            aiv_pkg::PORT_VBANK:  n_bank = i_item.write_data;
                            aiv_pkg::PORT_LAYOUT: n_wide = (i_item.write_data != 8'h00);
                            default: ;
                        endcase
                    end
                end
                // Key down pulls an input bit low, key up lets it go high.
                aiv_pkg::OP_KEY_DN: begin
                    if (i_item.key_index[3]) begin
                        n_in1 = r_in1 & ~key_mask;
                    end else begin
                        n_in0 = r_in0 & ~key_mask;
                    end
                end
                aiv_pkg::OP_KEY_UP: begin
                    if (i_item.key_index[3]) begin
                        n_in1 = r_in1 | key_mask;
                    end else begin
                        n_in0 = r_in0 | key_mask;
                    end
                end
                default: ;
            endcase
        end else begin
            o_resp.audio_stop  = 1'b0;
            o_resp.sound_write = 1'b0;
            o_resp.sound_data  = 8'h00;
        end
    end

    // Port state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dip_a <= aiv_pkg::DIP_A_RESET;
            r_dip_b <= aiv_pkg::DIP_B_RESET;
            r_in0   <= aiv_pkg::PORT_IN_RESET;
            r_in1   <= aiv_pkg::PORT_IN_RESET;
            r_scx   <= '0;
            r_scy   <= '0;
            r_rom   <= '0;
            r_bank  <= '0;
            r_bg    <= 1'b1;
            r_spr   <= 1'b1;
            r_txt   <= 1'b1;
            r_wide  <= 1'b0;
        end else begin
            r_dip_a <= n_dip_a;
            r_dip_b <= n_dip_b;
            r_in0   <= n_in0;
            r_in1   <= n_in1;
            r_scx   <= n_scx;
            r_scy   <= n_scy;
            r_rom   <= n_rom;
            r_bank  <= n_bank;
            r_bg    <= n_bg;
            r_spr   <= n_spr;
            r_txt   <= n_txt;
            r_wide  <= n_wide;
        end
    end

    // Video control state as seen by the display side.
    always_comb begin
        o_state.rom_bank      = r_rom;
        o_state.scroll_x      = signed'(r_scx);
        o_state.scroll_y      = signed'(r_scy);
        o_state.background_on = r_bg;
        o_state.sprites_on    = r_spr;
        o_state.text_on       = r_txt;
        o_state.wide_layout   = r_wide;
        o_state.vram_bank     = r_bank[1:0];
    end

endmodule

[hw/rtl/arcade_io_ports_and_banked_vram_unit.sv]
// Top level of the arcade I/O port and banked video RAM unit.
// Depends on aiv_pkg, aiv_ports and aiv_vram.
//
// Each item (port access, video RAM access or key event) is taken when start
// is high and busy is low; busy never rises, so an item can be given every
// cycle. Every item gives exactly one result, shown for one cycle with o_done
// high in the cycle after the item is taken, since the video RAM read data is
// registered. The receiver cannot stall and must take each result as it
// comes. The result carries the video control state as left by its item.
// Video RAM contents are undefined until written. DIP switches are written on
// the configuration port, which is always ready and should be used only while
// no item is in flight.
module arcade_io_ports_and_banked_vram_unit #(
    parameter int BANK_BYTES = aiv_pkg::BANK_BYTES,
    parameter int BANK_COUNT = aiv_pkg::BANK_COUNT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  aiv_pkg::t_item   i_item,
    output logic             o_done,
    output aiv_pkg::t_result o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [7:0]       i_cfg_data
);
    logic                  accept;
    logic                  cfg_wr;
    aiv_pkg::t_video_state vstate;
    aiv_pkg::t_port_resp   presp;
    logic [7:0]            vram_rd_data;
    logic                  vram_wr;
    logic                  vram_rd;

    logic                  r_done;
    logic                  r_vram_sel;
    aiv_pkg::t_port_resp   r_resp;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start & ~busy;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;
    assign vram_wr     = accept && (i_item.opcode == aiv_pkg::OP_VRAM_WR);
    assign vram_rd     = accept && (i_item.opcode == aiv_pkg::OP_VRAM_RD);

    aiv_ports u_ports (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_state     (vstate),
        .o_resp      (presp)
    );

    aiv_vram #(
        .BANK_BYTES (BANK_BYTES),
        .BANK_COUNT (BANK_COUNT)
    ) u_vram (
        .i_clk     (i_clk),
        .i_wr_en   (vram_wr),
        .i_rd_en   (vram_rd),
        .i_bank    (vstate.vram_bank),
        .i_offset  (i_item.address),
        .i_wr_data (i_item.write_data),
        .o_rd_data (vram_rd_data)
    );

    // Result stage: lines up the port side with the memory read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vram_sel <= vram_rd;
            r_resp     <= presp;
        end
    end

    // Result item assembly.
    always_comb begin
        o_result.read_data     = r_vram_sel ? vram_rd_data : r_resp.port_data;
        o_result.rom_bank      = vstate.rom_bank;
        o_result.scroll_x      = vstate.scroll_x;
        o_result.scroll_y      = vstate.scroll_y;
        o_result.background_on = vstate.background_on;
        o_result.sprites_on    = vstate.sprites_on;
        o_result.text_on       = vstate.text_on;
        o_result.wide_layout   = vstate.wide_layout;
        o_result.vram_bank     = vstate.vram_bank;
        o_result.audio_stop    = r_resp.audio_stop;
        o_result.sound_write   = r_resp.sound_write;
        o_result.sound_data    = r_resp.sound_data;
    end

    assign o_done = r_done;

endmodule

[verif/arcade_io_ports_and_banked_vram_unit_tb.sv]
// Self-checking testbench for the arcade I/O port and banked video RAM unit.
// Depends on aiv_pkg and arcade_io_ports_and_banked_vram_unit. It predicts
// each result in-line and checks directed and random bus accesses and key events.
module arcade_io_ports_and_banked_vram_unit_tb;
    import aiv_pkg::*;

    // The two opcodes with no meaning; they must leave the state alone.
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;
    localparam int RESULT_LATENCY = 1;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 126;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_item      i_item = '0;
    logic       o_done;
    t_result    o_result;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_index = CFG_DIP_A;
    logic [7:0] i_cfg_data = '0;

    // Items waiting to be sent and results owed by the block.
    t_item   bus_accesses_queued[$];
    t_result responses_due[$];
    int      gap_pct = 27;
    int      mismatches = 0;
    int      quiet_cycles = 0;

    // Predicted block state.
    logic [7:0] port_mem [0:15];
    logic [7:0] vram_model [0:16383];
    logic [7:0] vbank_sel;
    logic [3:0] rom_bank_q;
    logic       show_bg;
    logic       show_spr;
    logic       show_text;
    logic       wide_map;
    logic [7:0] dip_a_model;
    logic [7:0] dip_b_model;

    // Stimulus bookkeeping, so that only written video RAM is ever read.
    logic [1:0]  gen_bank = 2'd0;
    bit          vram_written [0:16383];
    logic [13:0] written_cells[$];

    arcade_io_ports_and_banked_vram_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Apply one accepted item to the predicted state and return its result.
    function automatic t_result bus_access_effect(t_item acc);
        t_result     res;
        logic [13:0] vram_addr;
        res = '0;
        vram_addr = {vbank_sel[1:0], acc.address};
        case (acc.opcode)
            OP_PORT_WR: begin
                if (acc.address == PORT_SOUND) begin
                    res.sound_write = 1'b1;
                    res.sound_data = acc.write_data;
                end else if (acc.address == PORT_ROMBANK) begin
                    rom_bank_q = acc.write_data[3:0];
                end else if (acc.address == PORT_CTRL) begin
                    res.audio_stop = acc.write_data[5];
                    show_text = !acc.write_data[7];
                end else if (acc.address >= PORT_SCX_LO && acc.address <= PORT_SCY_HI) begin
                    port_mem[acc.address[3:0]] = acc.write_data;
                end else if (acc.address == PORT_LAYERS) begin
                    show_bg = !acc.write_data[1];
                    show_spr = !acc.write_data[2];
                end else if (acc.address == PORT_VBANK) begin
                    vbank_sel = acc.write_data;
                end else if (acc.address == PORT_LAYOUT) begin
                    wide_map = (acc.write_data != 8'd0);
                end
            end
            OP_PORT_RD: begin
                if (acc.address == PORT_DIP_A)
                    res.read_data = dip_a_model;
                else if (acc.address == PORT_DIP_B)
                    res.read_data = dip_b_model;
                else if (acc.address <= PORT_LAST)
                    res.read_data = port_mem[acc.address[3:0]];
            end
            OP_VRAM_WR: vram_model[vram_addr] = acc.write_data;
            OP_VRAM_RD: res.read_data = vram_model[vram_addr];
            OP_KEY_DN: begin
                if (acc.key_index[3])
                    port_mem[PORT_IN1][acc.key_index[2:0]] = 1'b0;
                else
                    port_mem[PORT_IN0][acc.key_index[2:0]] = 1'b0;
            end
            OP_KEY_UP: begin
                if (acc.key_index[3])
                    port_mem[PORT_IN1][acc.key_index[2:0]] = 1'b1;
                else
                    port_mem[PORT_IN0][acc.key_index[2:0]] = 1'b1;
            end
            default: ;
        endcase
        res.rom_bank = rom_bank_q;
        res.scroll_x = {port_mem[PORT_SCX_HI], port_mem[PORT_SCX_LO]};
        res.scroll_y = {port_mem[PORT_SCY_HI], port_mem[PORT_SCY_LO]};
        res.background_on = show_bg;
        res.sprites_on = show_spr;
        res.text_on = show_text;
        res.wide_layout = wide_map;
        res.vram_bank = vbank_sel[1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %h, predicted %h", name, got, want));
    endtask

    // Queue one item and track which video RAM cells it leaves written.
    task automatic queue_access(input logic [2:0] op, input logic [11:0] addr,
                                input logic [7:0] data, input logic [3:0] key);
        t_item acc;
        logic [13:0] vram_addr;
        acc.opcode = op;
        acc.address = addr;
        acc.write_data = data;
        acc.key_index = key;
        vram_addr = {gen_bank, addr};
        if (op == OP_PORT_WR && addr == PORT_VBANK)
            gen_bank = data[1:0];
        if (op == OP_VRAM_WR && !vram_written[vram_addr]) begin
            vram_written[vram_addr] = 1'b1;
            written_cells.push_back(vram_addr);
        end
        bus_accesses_queued.push_back(acc);
    endtask

    // One random item, weighted toward the accesses that change or show state.
    task automatic queue_random_access();
        int          pick;
        logic [11:0] addr;
        logic [13:0] cand;
        logic [2:0]  op;
        bit          found;
        pick = $urandom_range(99);
        addr = ($urandom_range(9) != 0) ? 12'($urandom_range(15))
                                         : 12'($urandom_range(16, 4095));
        found = 1'b0;
        if (pick < 25) begin
            op = OP_PORT_WR;
        end else if (pick < 40) begin
            op = OP_PORT_RD;
        end else if (pick < 60) begin
            op = OP_VRAM_WR;
            addr = 12'($urandom);
        end else if (pick < 75) begin
            // Reads only go to cells already written in the bank in use.
            op = OP_VRAM_WR;
            addr = 12'($urandom);
            for (int tries = 0; tries < 8 && !found && written_cells.size() != 0; tries++) begin
                cand = written_cells[$urandom_range(written_cells.size() - 1)];
                if (cand[13:12] == gen_bank) begin
                    found = 1'b1;
                    op = OP_VRAM_RD;
                    addr = cand[11:0];
                end
            end
        end else if (pick < 86) begin
            op = OP_KEY_DN;
        end else if (pick < 97) begin
            op = OP_KEY_UP;
        end else begin
            op = $urandom_range(1) ? OP_UNUSED_7 : OP_UNUSED_6;
        end
        queue_access(op, addr, 8'($urandom), 4'($urandom));
    endtask

    // Write one DIP switch register while nothing is in flight.
    task automatic write_dip_switch(input logic idx, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        if (idx == CFG_DIP_A)
            dip_a_model = value;
        else
            dip_b_model = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Polled at the falling edge so that all updates of the rising edge are seen.
    task automatic wait_until_drained();
        do @(negedge i_clk);
        while (bus_accesses_queued.size() != 0 || start || responses_due.size() != 0);
        repeat (RESULT_LATENCY + 3) @(negedge i_clk);
    endtask

    // Driver: predicts each accepted item and offers the next one after a random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                responses_due.push_back(bus_access_effect(i_item));
            if (!start || !busy) begin
                if (bus_accesses_queued.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    start <= 1'b1;
                    i_item <= bus_accesses_queued.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (responses_due.size() == 0) begin
                report_mismatch("result with no item outstanding");
            end else begin
                want = responses_due.pop_front();
                check_field("read_data", 16'(o_result.read_data), 16'(want.read_data));
                check_field("rom_bank", 16'(o_result.rom_bank), 16'(want.rom_bank));
                check_field("scroll_x", o_result.scroll_x, want.scroll_x);
                check_field("scroll_y", o_result.scroll_y, want.scroll_y);
                check_field("background_on", 16'(o_result.background_on),
                            16'(want.background_on));
                check_field("sprites_on", 16'(o_result.sprites_on), 16'(want.sprites_on));
                check_field("text_on", 16'(o_result.text_on), 16'(want.text_on));
                check_field("wide_layout", 16'(o_result.wide_layout), 16'(want.wide_layout));
                check_field("vram_bank", 16'(o_result.vram_bank), 16'(want.vram_bank));
                check_field("audio_stop", 16'(o_result.audio_stop), 16'(want.audio_stop));
                check_field("sound_write", 16'(o_result.sound_write), 16'(want.sound_write));
                check_field("sound_data", 16'(o_result.sound_data), 16'(want.sound_data));
            end
        end
    end

    // Watchdog: too long without any item, result or register write ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sequence: reset, directed items, then random phases under several DIP settings.
    initial begin
        logic [7:0] dip_a_set [5];
        logic [7:0] dip_b_set [5];
        for (int p = 0; p < 16; p++)
            port_mem[p] = 8'd0;
        port_mem[PORT_IN0] = PORT_IN_RESET;
        port_mem[PORT_IN1] = PORT_IN_RESET;
        port_mem[PORT_IN2] = PORT_IN_RESET;
        port_mem[PORT_IN5] = PORT_IN5_VALUE;
        vbank_sel = 8'd0;
        rom_bank_q = 4'd0;
        show_bg = 1'b1;
        show_spr = 1'b1;
        show_text = 1'b1;
        wide_map = 1'b0;
        dip_a_model = DIP_A_RESET;
        dip_b_model = DIP_B_RESET;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset values of the input ports and the DIP switches.
        queue_access(OP_PORT_RD, PORT_IN0, 8'h00, 4'd0);
        queue_access(OP_PORT_RD, PORT_DIP_A, 8'h00, 4'd0);
        queue_access(OP_PORT_RD, PORT_DIP_B, 8'h00, 4'd0);
        queue_access(OP_PORT_RD, PORT_IN5, 8'h00, 4'd0);
        // Every port with an effect, some at the extremes of the written byte.
        queue_access(OP_PORT_WR, PORT_SOUND, 8'hff, 4'd0);
        queue_access(OP_PORT_WR, PORT_ROMBANK, 8'hff, 4'd0);
        queue_access(OP_PORT_WR, PORT_CTRL, 8'ha0, 4'd0);
        queue_access(OP_PORT_WR, PORT_CTRL, 8'h00, 4'd0);
        queue_access(OP_PORT_WR, PORT_SCX_LO, 8'h00, 4'd0);
        queue_access(OP_PORT_WR, PORT_SCX_HI, 8'h80, 4'd0);
        queue_access(OP_PORT_WR, PORT_SCY_LO, 8'hff, 4'd0);
        queue_access(OP_PORT_WR, PORT_SCY_HI, 8'h7f, 4'd0);
        queue_access(OP_PORT_WR, PORT_LAYERS, 8'h06, 4'd0);
        queue_access(OP_PORT_WR, PORT_VBANK, 8'hff, 4'd0);
        queue_access(OP_PORT_WR, PORT_LAYOUT, 8'h01, 4'd0);
        // Ports that store nothing, and port numbers past the last port.
        queue_access(OP_PORT_WR, PORT_LAST, 8'h55, 4'd0);
        queue_access(OP_PORT_WR, 12'hfff, 8'haa, 4'd0);
        queue_access(OP_PORT_RD, 12'hfff, 8'h00, 4'd0);
        // Highest cell of the highest bank, then the lowest key of IN0 and the highest of IN1.
        queue_access(OP_VRAM_WR, 12'hfff, 8'hff, 4'd15);
        queue_access(OP_VRAM_RD, 12'hfff, 8'h00, 4'd0);
        queue_access(OP_KEY_DN, 12'd0, 8'h00, 4'd0);
        queue_access(OP_KEY_DN, 12'd0, 8'h00, 4'd15);
        queue_access(OP_KEY_UP, 12'd0, 8'h00, 4'd15);
        queue_access(OP_PORT_RD, PORT_IN1, 8'h00, 4'd0);
        queue_access(OP_UNUSED_6, 12'hfff, 8'hff, 4'd15);
        queue_access(OP_UNUSED_7, 12'd0, 8'h00, 4'd0);
        wait_until_drained();

        dip_a_set = '{8'h00, 8'hff, 8'($urandom), 8'ha5, 8'($urandom)};
        dip_b_set = '{8'hff, 8'h00, 8'($urandom), 8'h5a, 8'($urandom)};
        for (int phase = 0; phase < 5; phase++) begin
            write_dip_switch(CFG_DIP_A, dip_a_set[phase]);
            write_dip_switch(CFG_DIP_B, dip_b_set[phase]);
            // One phase runs back to back with no gaps at all.
            gap_pct = (phase == 2) ? 0 : 27;
            @(negedge i_clk);
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_random_access();
            wait_until_drained();
        end

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
